// File: rtl/core/fws_pkg.sv
package fws_pkg;

  localparam int MAX_HARMONICS_DEF = 128;
  localparam int PHASE_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 13;

  localparam int ACC_W = 48;
  localparam int WGT_W = 21;
  localparam int SIN_W = 16;
  localparam int VAL_W = 66;

  localparam logic [16:0] K_SQUARE = 17'd83443;
  localparam logic [16:0] K_TRIANGLE = 17'd53121;
  localparam logic [7:0] HARM_COUNT_RESET = 8'd100;
  localparam logic [0:0] IDX_HARM_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_SQUARE = 2'd0,
    CMD_SAW    = 2'd1,
    CMD_TRI    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctl_t;

  typedef logic [15:0] qsin_tab_t [0:256];

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k <= 256; k++) begin
      u = 64'(k) << 22;
      u2 = (u * u) >> 30;
      r = 64'd172272;
      r = 64'd5026995 - ((u2 * r) >> 30);
      r = 64'd85569306 - ((u2 * r) >> 30);
      r = 64'd693598669 - ((u2 * r) >> 30);
      r = 64'd1686629713 - ((u2 * r) >> 30);
      s = (u * r) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      t[k] = 16'(v);
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage

// File: rtl/core/fourier_waveform_synth_top.sv
// Band-limited square, sawtooth and triangle synthesis by Fourier partial sum.
// Each input beat carries a waveform command and a phase in fractions of a
// turn; each output beat carries one Q3.13 sample and a saturation flag. The
// harmonic count register at byte address 0 sets how many terms are summed.
// The block accepts one beat per clock and returns results in order. Each
// beat passes through MAX_HARMONICS + 1 stages that each look up one
// harmonic and add the term of the one before it, then through three
// stages that scale, round and saturate. Any stall on the output side holds
// the whole pipeline.
module fourier_waveform_synth_top
  import fws_pkg::*;
#(
  parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int OUTPUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [15:0]        phase,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               saturated
);

  localparam int H = MAX_HARMONICS;
  localparam int CW = $clog2(MAX_HARMONICS + 1);
  localparam int PB = PHASE_BITS;

  logic [7:0]         harm_count;
  logic               adv;
  logic [PB+15:0]     ph_ext;
  logic [CW-1:0]      cnt_eff;

  ctl_t                    ctl_b  [0:H+1];
  logic [CW-1:0]           cnt_b  [0:H+1];
  logic [PB-1:0]           step_b [0:H+1];
  logic [PB-1:0]           ph_b   [0:H+1];
  logic signed [SIN_W-1:0] sn_b   [0:H+1];
  logic signed [ACC_W-1:0] acc_b  [0:H+1];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == IDX_HARM_COUNT) ? {24'b0, harm_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      harm_count <= HARM_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == IDX_HARM_COUNT) begin
      harm_count <= pwdata[7:0];
    end
  end

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign ph_ext = {{PB{1'b0}}, phase};

  always_comb begin
    if (int'(harm_count) > MAX_HARMONICS) begin
      cnt_eff = CW'(MAX_HARMONICS);
    end else begin
      cnt_eff = CW'(harm_count);
    end
  end

  always_comb begin
    ctl_b[0].valid = in_valid;
    ctl_b[0].cmd = cmd_t'(command);
    cnt_b[0] = cnt_eff;
    ph_b[0] = ph_ext[PB-1:0];
    step_b[0] = (cmd_t'(command) == CMD_SAW) ? ph_b[0] : {ph_b[0][PB-2:0], 1'b0};
    sn_b[0] = '0;
    acc_b[0] = '0;
  end

  for (genvar g = 0; g <= H; g++) begin : g_stage
    fws_stage #(
      .IDX(g),
      .PHASE_BITS(PB),
      .CW(CW)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .ctl_in(ctl_b[g]),
      .cnt_in(cnt_b[g]),
      .step_in(step_b[g]),
      .ph_in(ph_b[g]),
      .sn_in(sn_b[g]),
      .acc_in(acc_b[g]),
      .ctl_out(ctl_b[g+1]),
      .cnt_out(cnt_b[g+1]),
      .step_out(step_b[g+1]),
      .ph_out(ph_b[g+1]),
      .sn_out(sn_b[g+1]),
      .acc_out(acc_b[g+1])
    );
  end

  fws_scale #(
    .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .ctl_in(ctl_b[H+1]),
    .acc_in(acc_b[H+1]),
    .out_valid(out_valid),
    .sample(sample),
    .saturated(saturated)
  );

endmodule

// File: rtl/core/fws_stage.sv
module fws_stage
  import fws_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int CW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  ctl_t                     ctl_in,
  input  logic [CW-1:0]            cnt_in,
  input  logic [PHASE_BITS-1:0]    step_in,
  input  logic [PHASE_BITS-1:0]    ph_in,
  input  logic signed [SIN_W-1:0]  sn_in,
  input  logic signed [ACC_W-1:0]  acc_in,
  output ctl_t                     ctl_out,
  output logic [CW-1:0]            cnt_out,
  output logic [PHASE_BITS-1:0]    step_out,
  output logic [PHASE_BITS-1:0]    ph_out,
  output logic signed [SIN_W-1:0]  sn_out,
  output logic signed [ACC_W-1:0]  acc_out
);

  // This stage looks up harmonic IDX and adds the term of harmonic IDX-1.
  localparam int NS = (IDX > 0) ? IDX : 1;
  localparam int NO = (IDX > 0) ? 2 * IDX - 1 : 1;
  localparam int W_SAW = ((1 << 20) + NS / 2) / NS;
  localparam int W_SQ = ((1 << 20) + NO / 2) / NO;
  localparam int W_TRI = ((1 << 20) + (NO * NO) / 2) / (NO * NO);
  localparam bit NEG = (IDX > 0) && (((IDX - 1) % 2) == 1);

  logic [9:0]                   p10;
  logic [8:0]                   tidx;
  logic signed [SIN_W-1:0]      mag;
  logic signed [SIN_W-1:0]      sn_next;
  logic [WGT_W-1:0]             wgt;
  logic signed [SIN_W+WGT_W:0]  term;
  logic signed [ACC_W-1:0]      acc_next;

  if (PHASE_BITS >= 10) begin : g_down
    assign p10 = ph_in[PHASE_BITS-1 -: 10];
  end else begin : g_up
    assign p10 = 10'(ph_in) << (10 - PHASE_BITS);
  end

  always_comb begin
    tidx = p10[8] ? 9'(9'd256 - {1'b0, p10[7:0]}) : {1'b0, p10[7:0]};
    mag = $signed(QSIN_TAB[tidx]);
    if ((CW + 1)'(IDX) < {1'b0, cnt_in}) begin
      sn_next = p10[9] ? -mag : mag;
    end else begin
      sn_next = '0;
    end
  end

  always_comb begin
    unique case (ctl_in.cmd)
      CMD_SAW: wgt = WGT_W'(W_SAW);
      CMD_TRI: wgt = WGT_W'(W_TRI);
      default: wgt = WGT_W'(W_SQ);
    endcase
    term = sn_in * $signed({1'b0, wgt});
    if (NEG && ctl_in.cmd == CMD_TRI) begin
      acc_next = acc_in - ACC_W'(term);
    end else begin
      acc_next = acc_in + ACC_W'(term);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_out.cmd <= ctl_in.cmd;
      cnt_out <= cnt_in;
      step_out <= step_in;
      ph_out <= ph_in + step_in;
      sn_out <= sn_next;
      acc_out <= acc_next;
    end
  end

endmodule

// File: rtl/core/fws_scale.sv
module fws_scale
  import fws_pkg::*;
#(
  parameter int OUTPUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  ctl_t                     ctl_in,
  input  logic signed [ACC_W-1:0]  acc_in,
  output logic                     out_valid,
  output logic signed [15:0]       sample,
  output logic                     saturated
);

  localparam int SH = 51 - OUTPUT_FRAC_BITS;
  localparam logic signed [VAL_W-1:0] RND = VAL_W'(1) <<< (SH - 1);
  localparam logic signed [VAL_W-1:0] HI_LIM = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] LO_LIM = -VAL_W'(32768);

  ctl_t                    ctl1;
  ctl_t                    ctl2;
  logic [16:0]             kk;
  logic signed [41:0]      mhi;
  logic signed [41:0]      mhi_next;
  logic [40:0]             mlo;
  logic [40:0]             mlo_next;
  logic signed [ACC_W:0]   sv;
  logic signed [ACC_W:0]   sv_next;
  logic signed [VAL_W-1:0] val;
  logic signed [VAL_W-1:0] val_next;
  logic signed [VAL_W-1:0] rnd;
  logic signed [15:0]      sample_next;
  logic                    sat_next;

  always_comb begin
    kk = (ctl_in.cmd == CMD_TRI) ? K_TRIANGLE : K_SQUARE;
    mhi_next = $signed(acc_in[ACC_W-1:24]) * $signed({1'b0, kk});
    mlo_next = 41'({1'b0, acc_in[23:0]} * {1'b0, kk});
    sv_next = ((ACC_W + 1)'(1) <<< 34) - (ACC_W + 1)'(acc_in);
  end

  always_comb begin
    if (ctl1.cmd == CMD_SAW) begin
      val_next = VAL_W'(sv) <<< 16;
    end else begin
      val_next = (VAL_W'(mhi) <<< 24) + $signed(VAL_W'(mlo));
    end
  end

  always_comb begin
    rnd = (val + RND) >>> SH;
    sat_next = 1'b0;
    if (ctl2.cmd == CMD_NONE) begin
      sample_next = '0;
    end else if (rnd > HI_LIM) begin
      sample_next = 16'sh7fff;
      sat_next = 1'b1;
    end else if (rnd < LO_LIM) begin
      sample_next = -16'sh8000;
      sat_next = 1'b1;
    end else begin
      sample_next = 16'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      ctl1.valid <= ctl_in.valid;
      ctl2.valid <= ctl1.valid;
      out_valid <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1.cmd <= ctl_in.cmd;
      ctl2.cmd <= ctl1.cmd;
      mhi <= mhi_next;
      mlo <= mlo_next;
      sv <= sv_next;
      val <= val_next;
      sample <= sample_next;
      saturated <= sat_next;
    end
  end

endmodule

// File: rtl/core/fws_checker.sv
module fws_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample,
  input logic        saturated
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(saturated))
    else $error("stalled output beat changed");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track the output stage");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> sample == 16'h7fff || sample == 16'h8000)
    else $error("saturation flag with an unclipped sample");

endmodule

bind fourier_waveform_synth_top fws_checker u_fws_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .sample(sample),
  .saturated(saturated)
);
